[sv/wsfr_pkg.sv]
// ============================================================================
// WebSocket frame receiver package
// Shared types and constants for the frame parser: parse phases, length
// escape codes, opcodes that need a reply, reply codes and field widths.
// ============================================================================
package wsfr_pkg;

    // Parse phase of the receiver.
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    // Result kind carried on the output tuser.
    typedef enum logic {
        KIND_HEADER  = 1'b0,
        KIND_PAYLOAD = 1'b1
    } t_kind;

    // Seven-bit length codes that escape to an extended length.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Last byte index of the extended length and key fields.
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    // Control opcodes that ask for a reply.
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // Reply codes.
    localparam logic [1:0] REPLY_NONE  = 2'd0;
    localparam logic [1:0] REPLY_PONG  = 2'd1;
    localparam logic [1:0] REPLY_CLOSE = 2'd2;

    // Output tdata width: 83 field bits padded to whole bytes.
    localparam int unsigned OUT_BITS  = 83;
    localparam int unsigned OUT_WIDTH = 88;

endpackage

[sv/websocket_frame_receiver.sv]
// ============================================================================
// WebSocket frame receiver
// Parses a received byte stream into frames: header fields, extended length,
// masking key, and unmasked payload bytes with a last mark per frame.
// ============================================================================
// Usage:
//   Raw bytes from the connection enter on the slave stream (s_axis_*), one
//   byte per transfer. Results leave on the master stream (m_axis_*): a header
//   result once the frame header (and key, if masked) is complete, then one
//   result per payload byte, unmasked. tuser tells the two kinds apart and
//   tlast marks the final result of a frame (the header result itself for an
//   empty payload). Header bytes other than the last one give no result.
//   Every result repeats the frame's FIN, RSV, opcode, mask bit and length;
//   the reply field asks for a pong or close on the final result only.
// Timing:
//   A result is registered and appears in the cycle after the byte that causes it is accepted.
//   One byte is accepted every cycle while the output is not stalled; the parse
//   step and the output register form a single stage, so the sustained rate is
//   one byte per cycle. When the receiver stalls, the pending result holds in
//   the output register and s_axis_tready drops until it is taken.
// Reset:
//   Synchronous, active low. The parser returns to waiting for the first
//   header byte and the output register is emptied.
module websocket_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Raw byte stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] byte_in
    // Parsed result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,    // [7:0] data_byte, [8] fin_flag,
                                         // [11:9] reserved_bits, [15:12] opcode,
                                         // [16] masked, [80:17] payload_length,
                                         // [82:81] reply, [87:83] zero
    output logic        m_axis_tuser,    // [0] kind
    output logic        m_axis_tlast     // last
);
    import wsfr_pkg::*;

    // Parser state.
    t_phase          r_phase,       n_phase;
    logic [2:0]      r_byte_count,  n_byte_count;
    logic [63:0]     r_remaining,   n_remaining;
    logic [63:0]     r_frame_len,   n_frame_len;
    logic [3:0][7:0] r_xor_key,     n_xor_key;
    logic [1:0]      r_key_index,   n_key_index;
    logic [8:0]      r_header_bits, n_header_bits;

    // Output register.
    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic                 r_out_last;
    logic [OUT_WIDTH-1:0] r_out_data;

    // Step results.
    logic                 in_fire;
    logic                 len_done;
    logic                 hdr_done;
    logic                 emit;
    t_kind                emit_kind;
    logic                 emit_last;
    logic [7:0]           emit_byte;
    logic [1:0]           emit_reply;
    logic [OUT_WIDTH-1:0] n_out_data;

    // A byte is taken when the output register is empty or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Next state and result of one parse step.
    always_comb begin
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_remaining   = r_remaining;
        n_frame_len   = r_frame_len;
        n_xor_key     = r_xor_key;
        n_key_index   = r_key_index;
        n_header_bits = r_header_bits;
        len_done      = 1'b0;
        hdr_done      = 1'b0;
        emit          = 1'b0;
        emit_kind     = KIND_HEADER;
        emit_last     = 1'b0;
        emit_byte     = 8'd0;

        if (in_fire) begin
            unique case (r_phase)
                PH_LEN: begin
                    n_header_bits[0] = s_axis_tdata[7];
                    n_byte_count     = 3'd0;
                    n_frame_len      = 64'd0;
                    if (s_axis_tdata[6:0] == LEN_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (s_axis_tdata[6:0] == LEN_EXT64) begin
                        n_phase = PH_EXT64;
                    end else begin
                        n_frame_len = {57'd0, s_axis_tdata[6:0]};
                        len_done    = 1'b1;
                    end
                end
                PH_EXT16: begin
                    n_frame_len = {r_frame_len[55:0], s_axis_tdata};
                    if (r_byte_count >= EXT16_LAST) begin
                        len_done = 1'b1;
                    end else begin
                        n_byte_count = r_byte_count + 3'd1;
                    end
                end
                PH_EXT64: begin
                    n_frame_len = {r_frame_len[55:0], s_axis_tdata};
                    if (r_byte_count >= EXT64_LAST) begin
                        len_done = 1'b1;
                    end else begin
                        n_byte_count = r_byte_count + 3'd1;
                    end
                end
                PH_KEY: begin
                    n_xor_key[r_byte_count[1:0]] = s_axis_tdata;
                    if (r_byte_count >= KEY_LAST) begin
                        n_byte_count = 3'd0;
                        hdr_done     = 1'b1;
                    end else begin
                        n_byte_count = r_byte_count + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    n_key_index = r_key_index + 2'd1;
                    n_remaining = r_remaining - 64'd1;
                    emit        = 1'b1;
                    emit_kind   = KIND_PAYLOAD;
                    emit_byte   = s_axis_tdata ^ r_xor_key[r_key_index];
                    if (n_remaining == 64'd0) begin
                        emit_last = 1'b1;
                        n_phase   = PH_HDR0;
                    end
                end
                default: begin
                    // First header byte; unused phase codes land here too.
                    n_header_bits = {s_axis_tdata[7], s_axis_tdata[6:4],
                                     s_axis_tdata[3:0], 1'b0};
                    n_frame_len   = 64'd0;
                    n_remaining   = 64'd0;
                    n_xor_key     = '0;
                    n_key_index   = 2'd0;
                    n_byte_count  = 3'd0;
                    n_phase       = PH_LEN;
                end
            endcase

            // Length known: read the key if masked, else finish the header.
            if (len_done) begin
                n_byte_count = 3'd0;
                n_xor_key    = '0;
                if (n_header_bits[0]) begin
                    n_phase = PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            // Header complete: give the header result.
            if (hdr_done) begin
                n_remaining = n_frame_len;
                n_key_index = 2'd0;
                emit        = 1'b1;
                emit_kind   = KIND_HEADER;
                if (n_frame_len == 64'd0) begin
                    emit_last = 1'b1;
                    n_phase   = PH_HDR0;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    // Reply request on the final result of ping and close frames.
    always_comb begin
        emit_reply = REPLY_NONE;
        if (emit_last) begin
            if (n_header_bits[4:1] == OP_PING) begin
                emit_reply = REPLY_PONG;
            end else if (n_header_bits[4:1] == OP_CLOSE) begin
                emit_reply = REPLY_CLOSE;
            end
        end
    end

    // Pack the result fields, highest field first.
    assign n_out_data = {{(OUT_WIDTH - OUT_BITS){1'b0}}, emit_reply, n_frame_len,
                         n_header_bits[0], n_header_bits[4:1], n_header_bits[7:5],
                         n_header_bits[8], emit_byte};

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_byte_count  <= 3'd0;
            r_remaining   <= 64'd0;
            r_frame_len   <= 64'd0;
            r_xor_key     <= '0;
            r_key_index   <= 2'd0;
            r_header_bits <= 9'd0;
        end else begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_remaining   <= n_remaining;
            r_frame_len   <= n_frame_len;
            r_xor_key     <= n_xor_key;
            r_key_index   <= n_key_index;
            r_header_bits <= n_header_bits;
        end
    end

    // Output register: loaded on each accepted byte, emptied on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_out_kind <= emit_kind;
            r_out_last <= emit_last;
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // A reply is only ever requested on the final result of a frame.
    a_reply_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[82:81] != REPLY_NONE)) |-> r_out_last)
        else $error("reply requested on a result that is not last");

    // A close reply belongs to a close frame.
    a_close_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[82:81] == REPLY_CLOSE))
            |-> (r_out_data[15:12] == OP_CLOSE))
        else $error("close reply on a frame that is not a close frame");

    // A header result that ends the frame has an empty payload.
    a_empty_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_HEADER) && r_out_last)
            |-> (r_out_data[80:17] == 64'd0))
        else $error("final header result with nonzero payload length");

    // In the payload phase at least one byte is still due.
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remaining != 64'd0))
        else $error("payload phase with no bytes remaining");

    // Input is held back only while a result waits in the output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_valid && !m_axis_tready))
        else $error("input stalled without a pending result");
`endif

endmodule

[verif/websocket_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// WebSocket frame receiver testbench
// Streams raw frame bytes into the receiver. The traffic is a handful of
// hand-picked frames followed by random frames of mixed length encodings,
// masking and opcodes. Both stream sides insert random gaps. A scoreboard
// object tracks the framing state, builds every expected header and payload
// result, and compares each result leaving the block field by field.
// ============================================================================
module websocket_frame_receiver_tb;
    import wsfr_pkg::*;

    // Output word as packed on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [4:0]  pad;
        logic [1:0]  reply;
        logic [63:0] length;
        logic        masked;
        logic [3:0]  opcode;
        logic [2:0]  rsv;
        logic        fin;
        logic [7:0]  data;
    } t_result_word;

    typedef struct {
        t_result_word word;
        t_kind        kind;
        logic         last;
    } t_result;

    // Tracks the framing state and holds the results still to come.
    class frame_scoreboard;
        t_phase      phase;
        logic [2:0]  byte_idx;
        logic [63:0] remaining;
        logic [63:0] frame_len;
        logic [31:0] xor_key;
        logic [1:0]  key_pos;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  opcode;
        logic        masked;
        t_result     pending_results[$];
        int unsigned mismatches;

        function new();
            phase      = PH_HDR0;
            byte_idx   = '0;
            remaining  = '0;
            frame_len  = '0;
            xor_key    = '0;
            key_pos    = '0;
            fin        = 1'b0;
            rsv        = '0;
            opcode     = '0;
            masked     = 1'b0;
            mismatches = 0;
        endfunction

        // Queue one result carrying the current frame's header fields.
        function void emit_result(t_kind kind, logic [7:0] data, logic last);
            t_result r;
            r.kind        = kind;
            r.last        = last;
            r.word.pad    = '0;
            r.word.data   = data;
            r.word.fin    = fin;
            r.word.rsv    = rsv;
            r.word.opcode = opcode;
            r.word.masked = masked;
            r.word.length = frame_len;
            r.word.reply  = REPLY_NONE;
            if (last && opcode == OP_PING)
                r.word.reply = REPLY_PONG;
            else if (last && opcode == OP_CLOSE)
                r.word.reply = REPLY_CLOSE;
            pending_results.push_back(r);
        endfunction

        // Header and key are in: announce the frame.
        function void header_complete();
            remaining = frame_len;
            key_pos   = '0;
            if (frame_len == 64'd0) begin
                phase = PH_HDR0;
                emit_result(KIND_HEADER, 8'h00, 1'b1);
            end else begin
                phase = PH_PAYLOAD;
                emit_result(KIND_HEADER, 8'h00, 1'b0);
            end
        endfunction

        // Length is in: a masked frame still needs its key.
        function void length_complete();
            byte_idx = '0;
            xor_key  = '0;
            if (masked)
                phase = PH_KEY;
            else
                header_complete();
        endfunction

        // Advance the framing state by one accepted byte.
        function void absorb_byte(logic [7:0] b);
            logic [7:0] key_byte;
            case (phase)
                PH_LEN: begin
                    masked    = b[7];
                    byte_idx  = '0;
                    frame_len = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        phase = PH_EXT16;
                    end else if (b[6:0] == LEN_EXT64) begin
                        phase = PH_EXT64;
                    end else begin
                        frame_len = {57'd0, b[6:0]};
                        length_complete();
                    end
                end
                PH_EXT16: begin
                    frame_len = {frame_len[55:0], b};
                    if (byte_idx >= EXT16_LAST)
                        length_complete();
                    else
                        byte_idx = byte_idx + 3'd1;
                end
                PH_EXT64: begin
                    frame_len = {frame_len[55:0], b};
                    if (byte_idx >= EXT64_LAST)
                        length_complete();
                    else
                        byte_idx = byte_idx + 3'd1;
                end
                PH_KEY: begin
                    xor_key[8 * byte_idx[1:0] +: 8] = xor_key[8 * byte_idx[1:0] +: 8] | b;
                    if (byte_idx >= KEY_LAST) begin
                        byte_idx = '0;
                        header_complete();
                    end else begin
                        byte_idx = byte_idx + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    key_byte  = xor_key[8 * key_pos +: 8];
                    key_pos   = key_pos + 2'd1;
                    remaining = remaining - 64'd1;
                    emit_result(KIND_PAYLOAD, b ^ key_byte, remaining == 64'd0);
                    if (remaining == 64'd0)
                        phase = PH_HDR0;
                end
                default: begin
                    fin       = b[7];
                    rsv       = b[6:4];
                    opcode    = b[3:0];
                    frame_len = '0;
                    remaining = '0;
                    xor_key   = '0;
                    key_pos   = '0;
                    byte_idx  = '0;
                    phase     = PH_LEN;
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(logic [87:0] tdata, logic tuser, logic tlast);
            t_result      exp_res;
            t_result_word act;
            act = tdata;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result tuser=%0d tlast=%0d tdata=%h",
                             $time, tuser, tlast, tdata);
                return;
            end
            exp_res = pending_results.pop_front();
            if (tuser !== exp_res.kind || tlast !== exp_res.last ||
                act.data !== exp_res.word.data || act.fin !== exp_res.word.fin ||
                act.rsv !== exp_res.word.rsv || act.opcode !== exp_res.word.opcode ||
                act.masked !== exp_res.word.masked || act.length !== exp_res.word.length ||
                act.reply !== exp_res.word.reply || act.pad !== exp_res.word.pad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result differs", $time);
                    $display("  exp kind=%0d last=%0d data=%h fin=%0d rsv=%0d op=%h",
                             exp_res.kind, exp_res.last, exp_res.word.data,
                             exp_res.word.fin, exp_res.word.rsv, exp_res.word.opcode);
                    $display("      mask=%0d len=%h reply=%0d pad=%h",
                             exp_res.word.masked, exp_res.word.length,
                             exp_res.word.reply, exp_res.word.pad);
                    $display("  act kind=%0d last=%0d data=%h fin=%0d rsv=%0d op=%h",
                             tuser, tlast, act.data, act.fin, act.rsv, act.opcode);
                    $display("      mask=%0d len=%h reply=%0d pad=%h",
                             act.masked, act.length, act.reply, act.pad);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    localparam int unsigned ITEM_TARGET = 1150;
    localparam int unsigned IDLE_LIMIT  = 2000;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_valid  = 1'b0;
    logic [7:0]  s_data   = 8'h00;
    logic        m_ready  = 1'b0;
    logic        no_gaps  = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    frame_scoreboard sb;
    int unsigned     idle_cycles = 0;
    int unsigned     bytes_sent  = 0;

    websocket_frame_receiver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offer one byte and hold it until the transfer completes.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Send a frame header and n_payload random payload bytes.
    // enc selects the length encoding: 0 seven-bit, 1 16-bit, 2 64-bit.
    task automatic send_frame(input logic [7:0] first, input logic use_mask,
                              input logic [63:0] len, input int unsigned enc,
                              input logic [31:0] key, input logic [63:0] n_payload);
        logic [6:0]  code;
        logic [63:0] n;
        int          i;
        code = (enc == 0) ? len[6:0] : (enc == 1) ? LEN_EXT16 : LEN_EXT64;
        send_byte(first);
        send_byte({use_mask, code});
        if (enc == 1) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        if (enc == 2) begin
            for (i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end
        if (use_mask) begin
            for (i = 0; i < 4; i++)
                send_byte(key[8 * i +: 8]);
        end
        for (n = 0; n < n_payload; n++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // One random well-formed frame, biased toward short payloads and control opcodes.
    task automatic random_frame();
        logic [7:0]  first;
        logic [63:0] len;
        int unsigned enc;
        int unsigned r;
        first[7]   = 1'($urandom_range(0, 1));
        first[6:4] = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 12)
            first[3:0] = OP_PING;
        else if (r < 24)
            first[3:0] = OP_CLOSE;
        else
            first[3:0] = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 70) begin
            enc = 0;
            len = ($urandom_range(0, 9) < 8) ? 64'($urandom_range(0, 12))
                                             : 64'($urandom_range(0, 125));
        end else if (r < 85) begin
            enc = 1;
            len = ($urandom_range(0, 9) < 8) ? 64'($urandom_range(0, 16))
                                             : 64'($urandom_range(0, 300));
        end else begin
            enc = 2;
            len = 64'($urandom_range(0, 16));
        end
        send_frame(first, 1'($urandom_range(0, 1)), len, enc, $urandom, len);
        // Occasionally switch between gappy traffic and full-rate stretches.
        if ($urandom_range(0, 4) == 0)
            no_gaps = ~no_gaps;
    endtask

    // Main stimulus.
    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty text frame: the header result is also the last one.
        send_frame(8'h81, 1'b0, 64'd0, 0, 32'h0, 64'd0);
        // Empty masked ping with an all-ones key: pong on the header result.
        send_frame(8'h89, 1'b1, 64'd0, 0, 32'hFFFF_FFFF, 64'd0);
        // Close with a 16-bit length of zero.
        send_frame(8'h88, 1'b0, 64'd0, 1, 32'h0, 64'd0);
        // No FIN, all RSV bits, unknown opcode, non-minimal 16-bit length, zero key.
        send_frame(8'h7F, 1'b1, 64'd3, 1, 32'h0, 64'd3);
        // All-zero first byte with a non-minimal 64-bit length.
        send_frame(8'h00, 1'b0, 64'd1, 2, 32'h0, 64'd1);

        while (bytes_sent < ITEM_TARGET)
            random_frame();

        // A 64-bit length with its top bit set is taken as is; only a few bytes follow.
        send_frame(8'hFF, 1'b1, {64{1'b1}}, 2, $urandom, 64'd4);
        s_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("websocket_frame_receiver: match");
        else
            $display("websocket_frame_receiver: mismatch");
        $finish;
    end

    // Result-side backpressure.
    initial begin
        int unsigned gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (no_gaps) begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Monitor both streams at every edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_axis_tready)
                sb.absorb_byte(s_data);
            if (m_axis_tvalid && m_ready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("websocket_frame_receiver: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

[filelist.f]
sv/wsfr_pkg.sv
sv/websocket_frame_receiver.sv
verif/websocket_frame_receiver_tb.sv
